[hw/rtl/bktf_pkg.sv]
// Shared package for the box tracker: constants, codes, divider request type
// and the fixed-point saturation and rounding helpers. No dependencies.
package bktf_pkg;

  localparam int CHANNELS_DEF = 4;

  localparam int POS_W   = 24;  // signed Q16.8
  localparam int SIZE_W  = 23;  // unsigned Q15.8
  localparam int VAR_W   = 32;  // unsigned Q24.8
  localparam int DT_W    = 17;  // Q1.16 seconds
  localparam int FUNC_W  = 2;
  localparam int GAIN_W  = 17;  // Q1.16, up to 1.0
  localparam int MUL_B_W = 33;
  localparam int PROD_W  = GAIN_W + 1 + MUL_B_W;
  localparam int WIDE_W  = 52;
  localparam int DIV_W   = 48;
  localparam int DEN_W   = 37;
  localparam int ITER_W  = 6;

  localparam logic [DT_W-1:0] DT_MIN = 17'd66;
  localparam logic [DT_W-1:0] DT_MAX = 17'd65536;
  localparam logic [GAIN_W-1:0] GAIN_ONE = 17'd65536;
  localparam logic signed [POS_W-1:0] ONE_Q8 = 24'sd256;

  localparam logic [ITER_W-1:0] ITERS_RS   = 6'd36;
  localparam logic [ITER_W-1:0] ITERS_GAIN = 6'd17;
  localparam logic [ITER_W-1:0] ITERS_VEL  = 6'd42;

  // configuration register indexes
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 16;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_POS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PROC_VEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_MEAS     = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_POS = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_INIT_VEL = 3'd4;

  localparam logic [CFG_DATA_W-1:0] RST_PROC_POS = 16'd256;
  localparam logic [CFG_DATA_W-1:0] RST_PROC_VEL = 16'd1024;
  localparam logic [CFG_DATA_W-1:0] RST_MEAS     = 16'd1024;
  localparam logic [CFG_DATA_W-1:0] RST_INIT_POS = 16'd2560;
  localparam logic [CFG_DATA_W-1:0] RST_INIT_VEL = 16'd25600;

  localparam logic [FUNC_W-1:0] FUNC_PREDICT = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_UPDATE  = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_INIT    = 2'd2;

  typedef struct packed {
    logic              start;
    logic [DIV_W-1:0]  dividend;
    logic [DEN_W-1:0]  divisor;
    logic [ITER_W-1:0] iters;
  } div_req_t;

  localparam logic signed [WIDE_W-1:0] S24_MAX = 52'sd8388607;
  localparam logic signed [WIDE_W-1:0] S24_MIN = -52'sd8388608;
  localparam logic [WIDE_W-1:0] U32_MAX = 52'hF_FFFF_FFFF;

  function automatic logic signed [POS_W-1:0] sat_s24(input logic signed [WIDE_W-1:0] v);
    if (v > S24_MAX) return S24_MAX[POS_W-1:0];
    if (v < S24_MIN) return S24_MIN[POS_W-1:0];
    return v[POS_W-1:0];
  endfunction

  function automatic logic [VAR_W-1:0] sat_u32(input logic [WIDE_W-1:0] v);
    if (v > {20'd0, U32_MAX[VAR_W-1:0]}) return U32_MAX[VAR_W-1:0];
    return v[VAR_W-1:0];
  endfunction

  // round half up of v / 2^16
  function automatic logic signed [WIDE_W-1:0] rnd16(input logic signed [WIDE_W-1:0] v);
    return (v + 52'sd32768) >>> 16;
  endfunction

  // variance after a gain: max(1, round((1-K)*var)), product given non-negative
  function automatic logic [VAR_W-1:0] shrink(input logic signed [PROD_W-1:0] p);
    logic [WIDE_W-1:0] t;
    t = $unsigned(rnd16(WIDE_W'(p)));
    if (t == '0) return 32'd1;
    return sat_u32(t);
  endfunction

endpackage

[hw/rtl/bktf_if.sv]
// Valid/ready channel interfaces for the box tracker's input and result sides.
// Depends on bktf_pkg for field widths.
interface bktf_in_if
  import bktf_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic [FUNC_W-1:0]        func;
  logic signed [POS_W-1:0]  box_x;
  logic signed [POS_W-1:0]  box_y;
  logic [SIZE_W-1:0]        box_w;
  logic [SIZE_W-1:0]        box_h;
  logic [DT_W-1:0]          dt;

  modport source (output valid, func, box_x, box_y, box_w, box_h, dt, input ready);
  modport sink   (input valid, func, box_x, box_y, box_w, box_h, dt, output ready);
endinterface

interface bktf_out_if
  import bktf_pkg::*;
;
  logic                     valid;
  logic                     ready;
  logic signed [POS_W-1:0]  out_x;
  logic signed [POS_W-1:0]  out_y;
  logic [SIZE_W-1:0]        out_w;
  logic [SIZE_W-1:0]        out_h;
  logic                     tracking;

  modport source (output valid, out_x, out_y, out_w, out_h, tracking, input ready);
  modport sink   (input valid, out_x, out_y, out_w, out_h, tracking, output ready);
endinterface

[hw/rtl/bktf_mul.sv]
// Shared registered multiplier: unsigned gain-like operand times signed operand.
// Depends on bktf_pkg.
module bktf_mul
  import bktf_pkg::*;
(
  input  logic                      clk,
  input  logic [GAIN_W-1:0]         a,
  input  logic signed [MUL_B_W-1:0] b,
  output logic signed [PROD_W-1:0]  prod_r
);

  always_ff @(posedge clk) begin
    prod_r <= $signed({1'b0, a}) * b;
  end

endmodule

[hw/rtl/bktf_div.sv]
// Restoring unsigned divider, one quotient bit per cycle, iteration count per request.
// Depends on bktf_pkg (div_req_t). Caller guarantees dividend >> iters < divisor.
module bktf_div
  import bktf_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  div_req_t         req,
  output logic             done_r,
  output logic [DIV_W-1:0] quo_r
);

  logic              busy_r;
  logic [ITER_W-1:0] cnt_r;
  logic [DEN_W-1:0]  rem_r;
  logic [DEN_W-1:0]  den_r;
  logic [DIV_W-1:0]  dvd_r;
  logic [DEN_W:0]    part;
  logic [DEN_W:0]    trial;

  assign part  = {rem_r, dvd_r[DIV_W-1]};
  assign trial = part - {1'b0, den_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (req.start) begin
        busy_r <= 1'b1;
        cnt_r  <= req.iters;
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == ITER_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      rem_r <= DEN_W'(req.dividend >> req.iters);
      dvd_r <= req.dividend << (ITER_W'(DIV_W) - req.iters);
      den_r <= req.divisor;
      quo_r <= '0;
    end else if (busy_r) begin
      dvd_r <= {dvd_r[DIV_W-2:0], 1'b0};
      if (!trial[DEN_W]) begin
        rem_r <= trial[DEN_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b1};
      end else begin
        rem_r <= part[DEN_W-1:0];
        quo_r <= {quo_r[DIV_W-2:0], 1'b0};
      end
    end
  end

endmodule

[hw/rtl/box_track_kalman_filter.sv]
// Box tracker: per-channel scalar Kalman filters run by a sequencer over one
// shared multiplier and one bit-serial divider. Update time is set by the
// divider (one quotient bit per cycle), which runs one Rs division and then up to
// three divisions per channel (gain, velocity gain, velocity step).
// One transaction at a time; reset (sync, rst_n low) clears track and state.
module box_track_kalman_filter
  import bktf_pkg::*;
#(
  parameter int CHANNELS = CHANNELS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  bktf_in_if.sink               in_ch,
  bktf_out_if.source            out_ch,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int CH_W = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;

  // sequencer states
  localparam logic [4:0] S_IDLE    = 5'd0;
  localparam logic [4:0] S_INIT    = 5'd1;
  localparam logic [4:0] S_DTSQ    = 5'd2;
  localparam logic [4:0] S_DTSQ_W  = 5'd3;
  localparam logic [4:0] S_P_VEL   = 5'd4;
  localparam logic [4:0] S_P_PVAR  = 5'd5;
  localparam logic [4:0] S_P_FIN   = 5'd6;
  localparam logic [4:0] S_U_RS    = 5'd7;
  localparam logic [4:0] S_U_RS_W  = 5'd8;
  localparam logic [4:0] S_U_K     = 5'd9;
  localparam logic [4:0] S_U_K_W   = 5'd10;
  localparam logic [4:0] S_U_KV    = 5'd11;
  localparam logic [4:0] S_U_KV_W  = 5'd12;
  localparam logic [4:0] S_U_M1    = 5'd13;
  localparam logic [4:0] S_U_M2    = 5'd14;
  localparam logic [4:0] S_U_M3    = 5'd15;
  localparam logic [4:0] S_U_M4    = 5'd16;
  localparam logic [4:0] S_U_VD_W  = 5'd17;
  localparam logic [4:0] S_U_M6    = 5'd18;
  localparam logic [4:0] S_OUT     = 5'd19;

  // result source
  localparam logic [1:0] RES_ZERO = 2'd0;
  localparam logic [1:0] RES_ECHO = 2'd1;
  localparam logic [1:0] RES_BOX  = 2'd2;

  logic [4:0] state_r, state_nxt;
  logic [CH_W-1:0] ch_r;
  logic            last_ch;
  logic            tv_r;
  logic [1:0]      res_mode_r;

  // config registers
  logic [CFG_DATA_W-1:0] ppn_r, pvn_r, meas_r, ipv_r, ivv_r;

  // captured transaction
  logic [FUNC_W-1:0]       func_r;
  logic signed [POS_W-1:0] bx_r, by_r;
  logic [SIZE_W-1:0]       bw_r, bh_r;
  logic [DT_W-1:0]         dt_r, dt_clamp;

  // filter state
  logic signed [POS_W-1:0] pos_r  [CHANNELS];
  logic signed [POS_W-1:0] vel_r  [CHANNELS];
  logic [VAR_W-1:0]        pvar_r [CHANNELS];
  logic [VAR_W-1:0]        vvar_r [CHANNELS];

  // working registers
  logic [32:0]             dtsq_r;
  logic [DT_W-1:0]         dt2;
  logic [35:0]             rs_r;
  logic [GAIN_W-1:0]       k_r, kv_r;
  logic signed [POS_W:0]   innov_r;
  logic                    neg_r;

  // output stage
  logic                    out_valid_r;
  logic signed [POS_W-1:0] ox_r, oy_r;
  logic [SIZE_W-1:0]       ow_r, oh_r;
  logic                    otrk_r;

  // shared units
  logic [GAIN_W-1:0]         mul_a;
  logic signed [MUL_B_W-1:0] mul_b;
  logic signed [PROD_W-1:0]  prod_r;
  div_req_t                  div_req;
  logic                      div_done;
  logic [DIV_W-1:0]          div_q;

  bktf_mul u_mul (.clk(clk), .a(mul_a), .b(mul_b), .prod_r(prod_r));
  bktf_div u_div (.clk(clk), .rst_n(rst_n), .req(div_req), .done_r(div_done), .quo_r(div_q));

  // ---- measurement and current channel ----
  logic signed [POS_W-1:0] meas [4];
  logic signed [POS_W-1:0] meas_cur, cur_pos, cur_vel;
  logic [VAR_W-1:0]        cur_pvar, cur_vvar;
  logic [32:0]             den;
  logic [DEN_W-1:0]        denv;
  logic signed [POS_W:0]   innov;
  logic [DIV_W-1:0]        prod_mag;
  logic signed [WIDE_W-1:0] vel_delta;

  always_comb begin
    meas[0] = sat_s24(WIDE_W'(bx_r) + WIDE_W'({1'b0, bw_r[SIZE_W-1:1]}));
    meas[1] = sat_s24(WIDE_W'(by_r) + WIDE_W'({1'b0, bh_r[SIZE_W-1:1]}));
    meas[2] = ($signed({1'b0, bw_r}) < ONE_Q8) ? ONE_Q8 : $signed({1'b0, bw_r});
    meas[3] = ($signed({1'b0, bh_r}) < ONE_Q8) ? ONE_Q8 : $signed({1'b0, bh_r});
    meas_cur = '0;
    for (int i = 0; i < 4; i++) begin
      if (i < CHANNELS && ch_r == CH_W'(i)) meas_cur = meas[i];
    end
  end

  assign cur_pos  = pos_r[ch_r];
  assign cur_vel  = vel_r[ch_r];
  assign cur_pvar = pvar_r[ch_r];
  assign cur_vvar = vvar_r[ch_r];
  assign last_ch  = (ch_r == CH_W'(CHANNELS - 1));

  assign dt_clamp = (in_ch.dt < DT_MIN) ? DT_MIN : ((in_ch.dt > DT_MAX) ? DT_MAX : in_ch.dt);
  assign dt2      = DT_W'((dtsq_r + 33'd32768) >> 16);
  assign den      = {1'b0, cur_pvar} + 33'(meas_r);
  assign denv     = DEN_W'(cur_vvar) + DEN_W'(rs_r);
  assign innov    = $signed({meas_cur[POS_W-1], meas_cur}) - $signed({cur_pos[POS_W-1], cur_pos});
  assign prod_mag = prod_r[PROD_W-1] ? DIV_W'(-prod_r) : DIV_W'(prod_r);
  assign vel_delta = neg_r ? -$signed({4'd0, div_q}) : $signed({4'd0, div_q});

  // ---- multiplier operand select ----
  always_comb begin
    mul_a = '0;
    mul_b = '0;
    case (state_r)
      S_DTSQ:   begin mul_a = dt_r;            mul_b = $signed({16'd0, dt_r}); end
      S_P_VEL:  begin mul_a = dt_r;            mul_b = MUL_B_W'(cur_vel); end
      S_P_PVAR: begin mul_a = dt2;             mul_b = $signed({1'b0, cur_vvar}); end
      S_U_M1:   begin mul_a = k_r;             mul_b = MUL_B_W'(innov_r); end
      S_U_M2:   begin mul_a = GAIN_ONE - k_r;  mul_b = $signed({1'b0, cur_pvar}); end
      S_U_M3:   begin mul_a = kv_r;            mul_b = MUL_B_W'(innov_r); end
      S_U_VD_W: begin mul_a = GAIN_ONE - kv_r; mul_b = $signed({1'b0, cur_vvar}); end
      default:  begin mul_a = '0;              mul_b = '0; end
    endcase
  end

  // ---- divider requests ----
  always_comb begin
    div_req = '0;
    case (state_r)
      S_U_RS: begin
        div_req.start    = 1'b1;
        div_req.dividend = {meas_r, 32'd0};
        div_req.divisor  = DEN_W'(dtsq_r);
        div_req.iters    = ITERS_RS;
      end
      S_U_K: begin
        div_req.start    = (den != '0);
        div_req.dividend = {cur_pvar, 16'd0};
        div_req.divisor  = DEN_W'(den);
        div_req.iters    = ITERS_GAIN;
      end
      S_U_KV: begin
        div_req.start    = (denv != '0);
        div_req.dividend = {cur_vvar, 16'd0};
        div_req.divisor  = denv;
        div_req.iters    = ITERS_GAIN;
      end
      S_U_M4: begin
        div_req.start    = 1'b1;
        div_req.dividend = prod_mag;
        div_req.divisor  = DEN_W'(dt_r);
        div_req.iters    = ITERS_VEL;
      end
      default: div_req = '0;
    endcase
  end

  // ---- sequencer ----
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_ch.valid) begin
          if (in_ch.func == FUNC_INIT || (in_ch.func == FUNC_UPDATE && !tv_r))
            state_nxt = S_INIT;
          else if (!tv_r)
            state_nxt = S_OUT;
          else if (in_ch.func == FUNC_PREDICT || in_ch.func == FUNC_UPDATE)
            state_nxt = S_DTSQ;
          else
            state_nxt = S_OUT;
        end
      end
      S_INIT:   state_nxt = S_OUT;
      S_DTSQ:   state_nxt = S_DTSQ_W;
      S_DTSQ_W: state_nxt = (func_r == FUNC_UPDATE) ? S_U_RS : S_P_VEL;
      S_P_VEL:  state_nxt = S_P_PVAR;
      S_P_PVAR: state_nxt = S_P_FIN;
      S_P_FIN:  state_nxt = last_ch ? S_OUT : S_P_VEL;
      S_U_RS:   state_nxt = S_U_RS_W;
      S_U_RS_W: if (div_done) state_nxt = S_U_K;
      S_U_K:    state_nxt = (den != '0) ? S_U_K_W : S_U_KV;
      S_U_K_W:  if (div_done) state_nxt = S_U_KV;
      S_U_KV:   state_nxt = (denv != '0) ? S_U_KV_W : S_U_M1;
      S_U_KV_W: if (div_done) state_nxt = S_U_M1;
      S_U_M1:   state_nxt = S_U_M2;
      S_U_M2:   state_nxt = S_U_M3;
      S_U_M3:   state_nxt = S_U_M4;
      S_U_M4:   state_nxt = S_U_VD_W;
      S_U_VD_W: if (div_done) state_nxt = S_U_M6;
      S_U_M6:   state_nxt = last_ch ? S_OUT : S_U_K;
      S_OUT:    if (!out_valid_r || out_ch.ready) state_nxt = S_IDLE;
      default:  state_nxt = S_IDLE;
    endcase
  end

  assign in_ch.ready = (state_r == S_IDLE);

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= S_IDLE;
    else        state_r <= state_nxt;
  end

  // ---- config port ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ppn_r  <= RST_PROC_POS;
      pvn_r  <= RST_PROC_VEL;
      meas_r <= RST_MEAS;
      ipv_r  <= RST_INIT_POS;
      ivv_r  <= RST_INIT_VEL;
    end else if (cfg_we) begin
      unique case (cfg_index)
        CFG_PROC_POS: ppn_r  <= cfg_data;
        CFG_PROC_VEL: pvn_r  <= cfg_data;
        CFG_MEAS:     meas_r <= cfg_data;
        CFG_INIT_POS: ipv_r  <= cfg_data;
        CFG_INIT_VEL: ivv_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // ---- transaction capture and control ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tv_r       <= 1'b0;
      ch_r       <= '0;
      res_mode_r <= RES_ZERO;
    end else begin
      if (state_r == S_IDLE && in_ch.valid) begin
        ch_r <= '0;
        if (in_ch.func == FUNC_INIT || (in_ch.func == FUNC_UPDATE && !tv_r))
          res_mode_r <= RES_ECHO;
        else if (!tv_r)
          res_mode_r <= RES_ZERO;
        else
          res_mode_r <= RES_BOX;
      end
      if (state_r == S_INIT) tv_r <= 1'b1;
      if ((state_r == S_P_FIN || state_r == S_U_M6) && !last_ch) ch_r <= ch_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_IDLE && in_ch.valid) begin
      func_r <= in_ch.func;
      bx_r   <= in_ch.box_x;
      by_r   <= in_ch.box_y;
      bw_r   <= in_ch.box_w;
      bh_r   <= in_ch.box_h;
      dt_r   <= dt_clamp;
    end
  end

  // ---- datapath working registers ----
  always_ff @(posedge clk) begin
    case (state_r)
      S_DTSQ_W: dtsq_r <= prod_r[32:0];
      S_U_RS_W: if (div_done) rs_r <= div_q[35:0];
      S_U_K: begin
        innov_r <= innov;
        if (den == '0) k_r <= '0;
      end
      S_U_K_W:  if (div_done) k_r <= div_q[GAIN_W-1:0];
      S_U_KV:   if (denv == '0) kv_r <= '0;
      S_U_KV_W: if (div_done) kv_r <= div_q[GAIN_W-1:0];
      S_U_M4:   neg_r <= prod_r[PROD_W-1];
      default: ;
    endcase
  end

  // ---- filter state ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < CHANNELS; i++) begin
        pos_r[i]  <= '0;
        vel_r[i]  <= '0;
        pvar_r[i] <= '0;
        vvar_r[i] <= '0;
      end
    end else begin
      case (state_r)
        S_INIT: begin
          for (int i = 0; i < CHANNELS; i++) begin
            pos_r[i]  <= (i < 4) ? meas[i % 4] : '0;
            vel_r[i]  <= '0;
            pvar_r[i] <= VAR_W'(ipv_r);
            vvar_r[i] <= VAR_W'(ivv_r);
          end
        end
        S_P_PVAR: pos_r[ch_r] <= sat_s24(WIDE_W'(cur_pos) + rnd16(WIDE_W'(prod_r)));
        S_P_FIN: begin
          pvar_r[ch_r] <= sat_u32(WIDE_W'(cur_pvar) + $unsigned(rnd16(WIDE_W'(prod_r)))
                                  + WIDE_W'(ppn_r));
          vvar_r[ch_r] <= sat_u32(WIDE_W'(cur_vvar) + WIDE_W'(pvn_r));
        end
        S_U_M2: pos_r[ch_r]  <= sat_s24(WIDE_W'(cur_pos) + rnd16(WIDE_W'(prod_r)));
        S_U_M3: pvar_r[ch_r] <= shrink(prod_r);
        S_U_VD_W: if (div_done) vel_r[ch_r] <= sat_s24(WIDE_W'(cur_vel) + vel_delta);
        S_U_M6: vvar_r[ch_r] <= shrink(prod_r);
        default: ;
      endcase
    end
  end

  // ---- box from state ----
  logic signed [POS_W-1:0] bp [4];
  logic signed [POS_W-1:0] est_w, est_h, est_x, est_y;

  always_comb begin
    for (int i = 0; i < 4; i++) bp[i] = (i < CHANNELS) ? pos_r[i % CHANNELS] : '0;
    est_w = (bp[2] < ONE_Q8) ? ONE_Q8 : bp[2];
    est_h = (bp[3] < ONE_Q8) ? ONE_Q8 : bp[3];
    est_x = sat_s24(WIDE_W'(bp[0]) - WIDE_W'(est_w >>> 1));
    est_y = sat_s24(WIDE_W'(bp[1]) - WIDE_W'(est_h >>> 1));
  end

  // ---- output register ----
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      out_valid_r <= 1'b1;
    end else if (out_ch.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (state_r == S_OUT && (!out_valid_r || out_ch.ready)) begin
      otrk_r <= tv_r;
      case (res_mode_r)
        RES_ECHO: begin
          ox_r <= bx_r; oy_r <= by_r; ow_r <= bw_r; oh_r <= bh_r;
        end
        RES_BOX: begin
          ox_r <= est_x; oy_r <= est_y;
          ow_r <= est_w[SIZE_W-1:0]; oh_r <= est_h[SIZE_W-1:0];
        end
        default: begin
          ox_r <= '0; oy_r <= '0; ow_r <= '0; oh_r <= '0;
        end
      endcase
    end
  end

  assign out_ch.valid    = out_valid_r;
  assign out_ch.out_x    = ox_r;
  assign out_ch.out_y    = oy_r;
  assign out_ch.out_w    = ow_r;
  assign out_ch.out_h    = oh_r;
  assign out_ch.tracking = otrk_r;

endmodule
